// File: hdl/pgg_pkg.sv
// Shared types and constants for the palette gradient generator.
// No dependencies; every other file in hdl/ imports this package.
package pgg_pkg;

	// default width of one color channel
	localparam int CHANNEL_BITS_DEF = 6;

	// per-segment blend weights never exceed 256
	localparam int WEIGHT_W = 9;

	// configuration register indexes
	localparam int CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_RAMP_MODE    = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_COLOR  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIDDLE_COLOR = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FINISH_COLOR = 4'd3;

	// ramp modes
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CYCLIC = 2'd2;

	// x/85 == ((x+1)*771) >> 16 for every x below 65536
	localparam int DIV85_RECIP = 771;
	localparam int DIV85_SHIFT = 16;

	typedef enum logic [1:0] {
		ANC_START,
		ANC_MIDDLE,
		ANC_FINISH
	} anchor_t;

	// divisor of the weighted sum; DIV_NONE forces black
	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_255,
		DIV_128,
		DIV_85
	} div_t;

	// one ramp segment: result = (wa*A + wb*B) / div
	typedef struct packed {
		logic [WEIGHT_W-1:0] wa;
		logic [WEIGHT_W-1:0] wb;
		anchor_t             sel_a;
		anchor_t             sel_b;
		div_t                div;
	} seg_t;

endpackage

// File: hdl/palette_gradient_generator.sv
// Top level of the palette gradient generator: config registers, pipeline.
// Depends on pgg_pkg, pgg_seg_decode and pgg_chan_div.
//
// Usage:
//   Input channel in_valid/in_ready: palette_index, one word a cycle while ready.
//   Output channel out_valid/out_ready carries red, green and blue.
//   Config channel cfg_valid/cfg_ready writes cfg_data to the register at
//   cfg_index (0 ramp_mode, 1 start, 2 middle, 3 finish); cfg_ready is
//   always high and writes to other indexes are dropped. Write config only
//   while the pipeline is empty.
// Timing:
//   Three register stages: input register, weighted-sum register, result
//   register, passed through in that order. Throughput is one word per
//   clock while out_ready is high; each stage holds one word.
// Stall:
//   When out_ready is low the result register holds; earlier stages keep
//   filling until all three are full, then in_ready drops.
// Reset:
//   arst_n clears all valid bits and sets ramp_mode 0, start and middle
//   black, finish white.
module palette_gradient_generator #(
	parameter int CHANNEL_BITS = pgg_pkg::CHANNEL_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pgg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [3*CHANNEL_BITS-1:0]        cfg_data,
	// palette index in
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       palette_index,
	// color out
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [CHANNEL_BITS-1:0]          red,
	output logic [CHANNEL_BITS-1:0]          green,
	output logic [CHANNEL_BITS-1:0]          blue
);
	import pgg_pkg::*;

	localparam int COLOR_W = 3 * CHANNEL_BITS;
	localparam int SUM_W   = CHANNEL_BITS + 8;
	localparam int PROD_W  = CHANNEL_BITS + WEIGHT_W;

	// config registers
	logic [MODE_W-1:0]  ramp_mode_q;
	logic [COLOR_W-1:0] start_color_q;
	logic [COLOR_W-1:0] middle_color_q;
	logic [COLOR_W-1:0] finish_color_q;

	// pipeline
	logic                    v_s1, v_s2, v_s3;
	logic [7:0]              idx_s1;
	logic [SUM_W-1:0]        sum_s2 [3];
	div_t                    div_s2;
	logic [CHANNEL_BITS-1:0] chan_s3 [3];

	logic adv1, adv2, adv3;

	seg_t                    seg;
	logic [SUM_W-1:0]        sum_d [3];
	logic [CHANNEL_BITS-1:0] chan_d [3];

	//--------------------------------------------------------------
	// Config port: always ready, a write is registered at the end of its accept cycle
	//--------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_mode_q    <= MODE_SINGLE;
			start_color_q  <= '0;
			middle_color_q <= '0;
			finish_color_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RAMP_MODE:    ramp_mode_q    <= cfg_data[MODE_W-1:0];
				REG_START_COLOR:  start_color_q  <= cfg_data;
				REG_MIDDLE_COLOR: middle_color_q <= cfg_data;
				REG_FINISH_COLOR: finish_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------
	// Flow control: a stage loads when it is empty or drains this cycle
	//--------------------------------------------------------------
	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	//--------------------------------------------------------------
	// Stage 1 -> 2: segment decode, two products per channel, add
	//--------------------------------------------------------------
	pgg_seg_decode u_decode (
		.idx  (idx_s1),
		.mode (ramp_mode_q),
		.seg  (seg)
	);

	for (genvar c = 0; c < 3; c++) begin : g_blend
		// channel 0 red (top bits), 1 green, 2 blue (low bits)
		localparam int LSB = (2 - c) * CHANNEL_BITS;

		logic [CHANNEL_BITS-1:0] s_ch, m_ch, f_ch;
		logic [CHANNEL_BITS-1:0] a_ch, b_ch;
		logic [PROD_W-1:0]       prod_a, prod_b, prod_sum;

		assign s_ch = start_color_q[LSB +: CHANNEL_BITS];
		assign m_ch = middle_color_q[LSB +: CHANNEL_BITS];
		assign f_ch = finish_color_q[LSB +: CHANNEL_BITS];

		always_comb begin
			unique case (seg.sel_a)
				ANC_START:  a_ch = s_ch;
				ANC_MIDDLE: a_ch = m_ch;
				ANC_FINISH: a_ch = f_ch;
				default:    a_ch = '0;
			endcase
			unique case (seg.sel_b)
				ANC_START:  b_ch = s_ch;
				ANC_MIDDLE: b_ch = m_ch;
				ANC_FINISH: b_ch = f_ch;
				default:    b_ch = '0;
			endcase
		end

		assign prod_a   = PROD_W'(seg.wa) * PROD_W'(a_ch);
		assign prod_b   = PROD_W'(seg.wb) * PROD_W'(b_ch);
		// weights sum to at most 256, so the total fits SUM_W bits
		assign prod_sum = prod_a + prod_b;
		assign sum_d[c] = prod_sum[SUM_W-1:0];
	end

	//--------------------------------------------------------------
	// Stage 2 -> 3: constant division and clamp per channel
	//--------------------------------------------------------------
	for (genvar c = 0; c < 3; c++) begin : g_div
		pgg_chan_div #(
			.CHANNEL_BITS (CHANNEL_BITS)
		) u_div (
			.sum  (sum_s2[c]),
			.div  (div_s2),
			.chan (chan_d[c])
		);
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) idx_s1 <= palette_index;
		if (adv2 && v_s1) begin
			sum_s2 <= sum_d;
			div_s2 <= seg.div;
		end
		if (adv3 && v_s2) chan_s3 <= chan_d;
	end

	assign out_valid = v_s3;
	assign red       = chan_s3[0];
	assign green     = chan_s3[1];
	assign blue      = chan_s3[2];

endmodule

// File: hdl/pgg_seg_decode.sv
// Segment decoder: maps palette index and ramp mode to blend weights,
// anchor selects and divisor. Depends on pgg_pkg.
module pgg_seg_decode (
	input  logic [7:0]                idx,
	input  logic [pgg_pkg::MODE_W-1:0] mode,
	output pgg_pkg::seg_t              seg
);
	import pgg_pkg::*;

	logic [WEIGHT_W-1:0] k9;
	logic [WEIGHT_W-1:0] j_mir;
	logic [WEIGHT_W-1:0] j_mid;
	logic [WEIGHT_W-1:0] j_top;

	assign k9    = {1'b0, idx};
	assign j_mir = k9 - 9'd127;
	assign j_mid = k9 - 9'd85;
	assign j_top = k9 - 9'd170;

	always_comb begin
		seg.wa    = '0;
		seg.wb    = '0;
		seg.sel_a = ANC_START;
		seg.sel_b = ANC_FINISH;
		seg.div   = DIV_NONE;
		if (idx != 8'd0) begin
			unique case (mode)
				MODE_SINGLE: begin
					seg.wa    = k9;
					seg.sel_a = ANC_START;
					seg.wb    = 9'd256 - k9;
					seg.sel_b = ANC_FINISH;
					seg.div   = DIV_255;
				end
				MODE_MIRROR: begin
					seg.div = DIV_128;
					if (k9 <= 9'd128) begin
						seg.wa    = k9;
						seg.sel_a = ANC_FINISH;
						seg.wb    = 9'd128 - k9;
						seg.sel_b = ANC_START;
					end else begin
						seg.wa    = j_mir;
						seg.sel_a = ANC_START;
						seg.wb    = 9'd128 - j_mir;
						seg.sel_b = ANC_FINISH;
					end
				end
				MODE_CYCLIC: begin
					seg.div = DIV_85;
					priority if (k9 <= 9'd85) begin
						seg.wa    = k9;
						seg.sel_a = ANC_MIDDLE;
						seg.wb    = 9'd86 - k9;
						seg.sel_b = ANC_START;
					end else if (k9 <= 9'd170) begin
						seg.wa    = j_mid;
						seg.sel_a = ANC_FINISH;
						seg.wb    = 9'd86 - j_mid;
						seg.sel_b = ANC_MIDDLE;
					end else begin
						seg.wa    = j_top;
						seg.sel_a = ANC_START;
						seg.wb    = 9'd86 - j_top;
						seg.sel_b = ANC_FINISH;
					end
				end
				default: begin
					// unused mode: black
					seg.div = DIV_NONE;
				end
			endcase
		end
	end

endmodule

// File: hdl/pgg_chan_div.sv
// Constant divider for one channel: weighted sum / 255, 128 or 85 (zero for DIV_NONE),
// then clamp to the channel range. Depends on pgg_pkg.
module pgg_chan_div #(
	parameter int CHANNEL_BITS = pgg_pkg::CHANNEL_BITS_DEF
) (
	input  logic [CHANNEL_BITS+7:0] sum,
	input  pgg_pkg::div_t           div,
	output logic [CHANNEL_BITS-1:0] chan
);
	import pgg_pkg::*;

	localparam int SUM_W = CHANNEL_BITS + 8;
	localparam int Q_W   = CHANNEL_BITS + 3;
	localparam int P85_W = SUM_W + 11;

	logic [SUM_W:0]   t255;
	logic [P85_W-1:0] p85;
	logic [Q_W-1:0]   q;
	logic [Q_W-1:0]   ch_max;

	// x/255 == (x + (x>>8) + 1) >> 8 below 65535
	assign t255 = {1'b0, sum} + (SUM_W+1)'(sum >> 8) + (SUM_W+1)'(1);
	assign p85  = P85_W'({1'b0, sum} + (SUM_W+1)'(1)) * P85_W'(DIV85_RECIP);
	assign ch_max = {3'b000, {CHANNEL_BITS{1'b1}}};

	always_comb begin
		unique case (div)
			DIV_255:  q = {2'b00, t255[SUM_W:8]};
			DIV_128:  q = {2'b00, sum[SUM_W-1:7]};
			DIV_85:   q = p85[P85_W-1:DIV85_SHIFT];
			DIV_NONE: q = '0;
		endcase
	end

	assign chan = (q > ch_max) ? {CHANNEL_BITS{1'b1}} : q[CHANNEL_BITS-1:0];

endmodule
